// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the viewport fit transform.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/vft_pkg.sv
// Package of the viewport fit transform: widths, reset values, codes and types.
// Used by vft_iter_unit, viewport_fit_transform and the testbench; depends on nothing.
package vft_pkg;

  // Default parameter values.
  localparam int unsigned COORD_WIDTH_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF   = 16;

  // Fixed field widths.
  localparam int unsigned WIN_W   = 12;
  localparam int unsigned SCALE_W = 32;
  localparam int unsigned OFF_W   = 32;
  localparam int unsigned NUM_W   = 64;

  // Configuration port.
  localparam int unsigned APB_DW = 32;
  localparam int unsigned APB_AW = 3;
  localparam logic        REG_WIDTH  = 1'b0;
  localparam logic        REG_HEIGHT = 1'b1;
  localparam logic [WIN_W-1:0] WIDTH_RST  = 12'd640;
  localparam logic [WIN_W-1:0] HEIGHT_RST = 12'd480;

  // Product magnitude limit and offset saturation bounds.
  localparam logic [NUM_W-2:0] MAG_CAP = {1'b1, {(NUM_W-2){1'b0}}};
  localparam logic [OFF_W-1:0] OFF_MAX = {1'b0, {(OFF_W-1){1'b1}}};
  localparam logic [OFF_W-1:0] OFF_MIN = {1'b1, {(OFF_W-1){1'b0}}};

  // Operation of the shared shift/add unit.
  typedef enum logic {
    OP_DIV,
    OP_MUL
  } vft_op_e;

  // Command from the sequencer to the shared unit.
  typedef struct packed {
    logic    start;
    vft_op_e op;
  } vft_cmd_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_DIV_X,
    S_DIV_Y,
    S_FIT,
    S_MUL_X,
    S_OFF_X,
    S_MUL_Y,
    S_OFF_Y,
    S_OUT
  } vft_state_e;

endpackage

// File: hw/rtl/vft_iter_unit.sv
// Shared iterative unit: restoring divide and shift-add multiply, one bit a cycle.
// Depends on vft_pkg for widths and the command type.
module vft_iter_unit
  import vft_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF,
  localparam int unsigned DNW   = WIN_W + FRAC_BITS,
  localparam int unsigned MW    = COORD_WIDTH + 1,
  localparam int unsigned AW    = (MW > SCALE_W + 1) ? MW : SCALE_W + 1,
  localparam int unsigned LW    = (DNW > MW) ? DNW : MW,
  localparam int unsigned CNT_W = $clog2(LW + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  vft_cmd_t      cmd_i,
  input  logic [LW-1:0] a_i,
  input  logic [AW-1:0] b_i,
  output logic          done_o,
  output logic [AW-1:0] hi_o,
  output logic [LW-1:0] lo_o
);

  logic             active_q;
  logic             done_q;
  vft_op_e          op_q;
  logic [CNT_W-1:0] cnt_q;
  logic [AW-1:0]    hi_q, hi_d;
  logic [LW-1:0]    lo_q, lo_d;
  logic [AW-1:0]    opd_q;

  logic             is_div;
  logic [AW-1:0]    trial;
  logic [AW-1:0]    add_a, add_b;
  logic [AW:0]      sum;
  logic             qbit;

  // One adder serves both operations: subtract for divide, add for multiply.
  always_comb begin
    is_div = (op_q == OP_DIV);
    trial  = {hi_q[AW-2:0], lo_q[DNW-1]};
    add_a  = is_div ? trial : hi_q;
    add_b  = is_div ? ~opd_q : (lo_q[0] ? opd_q : '0);
    sum    = {1'b0, add_a} + {1'b0, add_b} + {{AW{1'b0}}, is_div};
    qbit   = sum[AW];
    if (is_div) begin
      hi_d = qbit ? sum[AW-1:0] : trial;
      lo_d = {lo_q[LW-2:0], qbit};
    end else begin
      hi_d = sum[AW:1];
      lo_d = {sum[0], lo_q[LW-1:1]};
    end
  end

  // Control: step counter and completion pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      op_q     <= OP_DIV;
      cnt_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        active_q <= 1'b1;
        op_q     <= cmd_i.op;
        cnt_q    <= (cmd_i.op == OP_DIV) ? CNT_W'(DNW) : CNT_W'(MW);
      end else if (active_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          active_q <= 1'b0;
          done_q   <= 1'b1;
        end
      end
    end
  end

  // Datapath: operands load on start, then shift once per step.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      hi_q  <= '0;
      lo_q  <= a_i;
      opd_q <= b_i;
    end else if (active_q) begin
      hi_q <= hi_d;
      lo_q <= lo_d;
    end
  end

  assign done_o = done_q;
  assign hi_o   = hi_q;
  assign lo_o   = lo_q;

endmodule

// File: hw/rtl/viewport_fit_transform.sv
// An item without the last mark is taken while busy is low, and busy stays low.
// A last item raises busy; the sequencer then runs PREP, the x and y divides, FIT,
// x multiply, x offset, y multiply, y offset and OUT; a zero extent skips its divide.
// Both divides and both multiplies run one bit a cycle in the shared shift/add unit.
// busy drops after the strobe, and no item is taken while busy; no receiver stall.
// Reset is asynchronous active low: window 640 by 480, empty set, sequencer idle.
`include "assert_macros.svh"

module viewport_fit_transform
  import vft_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Configuration port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [APB_AW-1:0]         paddr,
  input  logic [APB_DW-1:0]         pwdata,
  output logic [APB_DW-1:0]         prdata,
  output logic                      pready,
  // Input item
  input  logic                      start,
  output logic                      busy,
  input  logic signed [COORD_WIDTH-1:0] box_min_x_i,
  input  logic signed [COORD_WIDTH-1:0] box_min_y_i,
  input  logic signed [COORD_WIDTH-1:0] box_max_x_i,
  input  logic signed [COORD_WIDTH-1:0] box_max_y_i,
  input  logic                      last_shape_i,
  // Result
  output logic                      result_strobe_o,
  output logic signed [COORD_WIDTH-1:0] scene_min_x_o,
  output logic signed [COORD_WIDTH-1:0] scene_min_y_o,
  output logic signed [COORD_WIDTH-1:0] scene_max_x_o,
  output logic signed [COORD_WIDTH-1:0] scene_max_y_o,
  output logic [SCALE_W-1:0]        fit_scale_o,
  output logic signed [SCALE_W:0]   scale_x_o,
  output logic signed [SCALE_W:0]   scale_y_o,
  output logic signed [OFF_W-1:0]   offset_a_o,
  output logic signed [OFF_W-1:0]   offset_b_o,
  output logic                      degenerate_o
);

  localparam int unsigned CW  = COORD_WIDTH;
  localparam int unsigned FB  = FRAC_BITS;
  localparam int unsigned DNW = WIN_W + FB;
  localparam int unsigned MW  = CW + 1;
  localparam int unsigned AW  = (MW > SCALE_W + 1) ? MW : SCALE_W + 1;
  localparam int unsigned LW  = (DNW > MW) ? DNW : MW;
  localparam int unsigned PW  = AW + MW;
  localparam int unsigned SH  = FB + 1;

  // Configuration registers and read-back.
  logic [WIN_W-1:0] width_q, height_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_HEIGHT) ? {{(APB_DW-WIN_W){1'b0}}, height_q}
                                           : {{(APB_DW-WIN_W){1'b0}}, width_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_HEIGHT) begin
        height_q <= pwdata[WIN_W-1:0];
      end else begin
        width_q <= pwdata[WIN_W-1:0];
      end
    end
  end

  // Sequencer state and input transfer.
  vft_state_e state_q, state_d;
  logic       accept;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  // Running box of the current set.
  logic                 set_empty_q;
  logic signed [CW-1:0] run_min_x_q, run_min_y_q, run_max_x_q, run_max_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_empty_q <= 1'b1;
    end else if (accept) begin
      set_empty_q <= last_shape_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (set_empty_q) begin
        run_min_x_q <= box_min_x_i;
        run_min_y_q <= box_min_y_i;
        run_max_x_q <= box_max_x_i;
        run_max_y_q <= box_max_y_i;
      end else begin
        if (box_min_x_i < run_min_x_q) run_min_x_q <= box_min_x_i;
        if (box_min_y_i < run_min_y_q) run_min_y_q <= box_min_y_i;
        if (box_max_x_i > run_max_x_q) run_max_x_q <= box_max_x_i;
        if (box_max_y_i > run_max_y_q) run_max_y_q <= box_max_y_i;
      end
    end
  end

  // Spans, extents, center sums and direction signs of the closed set.
  logic [CW:0]   dx, dy, dx_abs, dy_abs, sumx, sumy, sumx_abs, sumy_abs;
  logic [CW-1:0] ex, ey;
  logic          ex_zero, ey_zero, sx_neg, sy_neg;

  always_comb begin
    dx       = {run_max_x_q[CW-1], run_max_x_q} - {run_min_x_q[CW-1], run_min_x_q};
    dy       = {run_max_y_q[CW-1], run_max_y_q} - {run_min_y_q[CW-1], run_min_y_q};
    dx_abs   = dx[CW] ? (~dx + 1'b1) : dx;
    dy_abs   = dy[CW] ? (~dy + 1'b1) : dy;
    ex       = dx_abs[CW-1:0];
    ey       = dy_abs[CW-1:0];
    ex_zero  = (dx == '0);
    ey_zero  = (dy == '0);
    sumx     = {run_min_x_q[CW-1], run_min_x_q} + {run_max_x_q[CW-1], run_max_x_q};
    sumy     = {run_min_y_q[CW-1], run_min_y_q} + {run_max_y_q[CW-1], run_max_y_q};
    sumx_abs = sumx[CW] ? (~sumx + 1'b1) : sumx;
    sumy_abs = sumy[CW] ? (~sumy + 1'b1) : sumy;
    // Screen x span is the width; screen y span is minus the height.
    sx_neg   = dx[CW];
    sy_neg   = (!dy[CW]) != (height_q == '0);
  end

  // Shared unit.
  vft_cmd_t      unit_cmd;
  logic [LW-1:0] unit_a;
  logic [AW-1:0] unit_b;
  logic          unit_done;
  logic [AW-1:0] unit_hi;
  logic [LW-1:0] unit_lo;

  vft_iter_unit #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (unit_cmd),
    .a_i    (unit_a),
    .b_i    (unit_b),
    .done_o (unit_done),
    .hi_o   (unit_hi),
    .lo_o   (unit_lo)
  );

  // Per-axis ratios and the fit scale.
  logic [SCALE_W-1:0]     rx_q, ry_q, lambda_q, lambda_d, ratio_d;
  logic [DNW+SCALE_W-1:0] quot_ext;
  logic [DNW-1:0]         numer_x, numer_y;

  assign numer_x = {width_q, {FB{1'b0}}};
  assign numer_y = {height_q, {FB{1'b0}}};

  always_comb begin
    quot_ext = {{SCALE_W{1'b0}}, unit_lo[DNW-1:0]};
    ratio_d  = (|quot_ext[DNW+SCALE_W-1:SCALE_W]) ? '1 : quot_ext[SCALE_W-1:0];
  end

  always_comb begin
    priority if (ex_zero && ey_zero) begin
      lambda_d = '1;
    end else if (ex_zero) begin
      lambda_d = ry_q;
    end else if (ey_zero) begin
      lambda_d = rx_q;
    end else begin
      lambda_d = (rx_q < ry_q) ? rx_q : ry_q;
    end
  end

  // Offset numerator: span scaled up minus the capped signed product.
  logic                    mul_y;
  logic [PW-1:0]           prod;
  logic [PW+NUM_W-1:0]     prod_ext;
  logic                    prod_big, prod_neg;
  logic [NUM_W-2:0]        mag;
  logic [WIN_W-1:0]        span;
  logic signed [NUM_W-1:0] span_fx, mag_ext, num_d, num_q;

  always_comb begin
    mul_y    = (state_q == S_MUL_Y);
    prod     = {unit_hi, unit_lo[LW-1 -: MW]};
    prod_ext = {{NUM_W{1'b0}}, prod};
    prod_big = (|prod_ext[PW+NUM_W-1:NUM_W-1])
               || (prod_ext[NUM_W-2] && (|prod_ext[NUM_W-3:0]));
    mag      = prod_big ? MAG_CAP : prod_ext[NUM_W-2:0];
    mag_ext  = $signed({1'b0, mag});
    span     = mul_y ? height_q : width_q;
    prod_neg = mul_y ? (sy_neg ^ sumy[CW]) : (sx_neg ^ sumx[CW]);
    span_fx  = $signed({{(NUM_W-WIN_W-FB){1'b0}}, span, {FB{1'b0}}});
    num_d    = prod_neg ? (span_fx + mag_ext) : (span_fx - mag_ext);
  end

  // Halve and unscale toward zero, then saturate to the offset range.
  logic signed [NUM_W-1:0] num_fl;
  logic [NUM_W-1:0]        num_tr;
  logic                    round_up, in_range;
  logic [OFF_W-1:0]        off_d, offa_q, offb_q;

  always_comb begin
    num_fl   = num_q >>> SH;
    round_up = num_q[NUM_W-1] && (|num_q[SH-1:0]);
    num_tr   = $unsigned(num_fl) + {{(NUM_W-1){1'b0}}, round_up};
    in_range = (&num_tr[NUM_W-1:OFF_W-1]) || (~|num_tr[NUM_W-1:OFF_W-1]);
    if (in_range) begin
      off_d = num_tr[OFF_W-1:0];
    end else begin
      off_d = num_tr[NUM_W-1] ? OFF_MIN : OFF_MAX;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept && last_shape_i) state_d = S_PREP;
      S_PREP: begin
        if (!ex_zero) begin
          state_d = S_DIV_X;
        end else if (!ey_zero) begin
          state_d = S_DIV_Y;
        end else begin
          state_d = S_FIT;
        end
      end
      S_DIV_X: if (unit_done) state_d = ey_zero ? S_FIT : S_DIV_Y;
      S_DIV_Y: if (unit_done) state_d = S_FIT;
      S_FIT:   state_d = S_MUL_X;
      S_MUL_X: if (unit_done) state_d = S_OFF_X;
      S_OFF_X: state_d = S_MUL_Y;
      S_MUL_Y: if (unit_done) state_d = S_OFF_Y;
      S_OFF_Y: state_d = S_OUT;
      S_OUT:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer outputs: unit commands and the result strobe.
  always_comb begin
    unit_cmd.start  = 1'b0;
    unit_cmd.op     = OP_DIV;
    unit_a          = '0;
    unit_b          = '0;
    result_strobe_o = 1'b0;
    unique case (state_q)
      S_PREP: begin
        if (!ex_zero) begin
          unit_cmd.start = 1'b1;
          unit_a         = LW'(numer_x);
          unit_b         = AW'(ex);
        end else if (!ey_zero) begin
          unit_cmd.start = 1'b1;
          unit_a         = LW'(numer_y);
          unit_b         = AW'(ey);
        end
      end
      S_DIV_X: begin
        if (unit_done && !ey_zero) begin
          unit_cmd.start = 1'b1;
          unit_a         = LW'(numer_y);
          unit_b         = AW'(ey);
        end
      end
      S_FIT: begin
        unit_cmd.start = 1'b1;
        unit_cmd.op    = OP_MUL;
        unit_a         = LW'(sumx_abs);
        unit_b         = AW'(lambda_d);
      end
      S_OFF_X: begin
        unit_cmd.start = 1'b1;
        unit_cmd.op    = OP_MUL;
        unit_a         = LW'(sumy_abs);
        unit_b         = AW'(lambda_q);
      end
      S_OUT: result_strobe_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Working registers captured along the sequence.
  always_ff @(posedge clk_i) begin
    if (state_q == S_DIV_X && unit_done) rx_q <= ratio_d;
    if (state_q == S_DIV_Y && unit_done) ry_q <= ratio_d;
    if (state_q == S_FIT) lambda_q <= lambda_d;
    if ((state_q == S_MUL_X || state_q == S_MUL_Y) && unit_done) num_q <= num_d;
    if (state_q == S_OFF_X) offa_q <= off_d;
    if (state_q == S_OFF_Y) offb_q <= off_d;
  end

  // Result fields.
  logic [SCALE_W:0] lam_ext;

  assign lam_ext       = {1'b0, lambda_q};
  assign scene_min_x_o = run_min_x_q;
  assign scene_min_y_o = run_min_y_q;
  assign scene_max_x_o = run_max_x_q;
  assign scene_max_y_o = run_max_y_q;
  assign fit_scale_o   = lambda_q;
  assign scale_x_o     = sx_neg ? (~lam_ext + 1'b1) : lam_ext;
  assign scale_y_o     = sy_neg ? (~lam_ext + 1'b1) : lam_ext;
  assign offset_a_o    = offa_q;
  assign offset_b_o    = offb_q;
  assign degenerate_o  = ex_zero && ey_zero;

  // Checks on the sequencing and the degenerate case.
  `ASSERT_NEXT(a_strobe_then_ready, result_strobe_o, !busy, "busy after result strobe")
  `ASSERT_NEXT(a_last_goes_busy, start && !busy && last_shape_i, busy, "last item not taken up")
  `ASSERT_NEXT(a_plain_stays_ready, start && !busy && !last_shape_i, !busy && !result_strobe_o, "plain item started work")
  `ASSERT_IMPLIES(a_degen_saturates, result_strobe_o && degenerate_o, fit_scale_o == '1, "degenerate scale not saturated")

endmodule

// File: bench/testbench.sv
// Testbench for viewport_fit_transform: shape boxes go in, fitted scene transforms come out.
// Depends on vft_pkg for widths and register indexes; a local predictor checks every result.
`timescale 1ns / 100ps

module testbench;
  import vft_pkg::*;

  localparam int unsigned CW = COORD_WIDTH_DEF;
  localparam int unsigned FB = FRAC_BITS_DEF;

  localparam logic [APB_AW-1:0] ADDR_WIDTH  = {REG_WIDTH, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_HEIGHT = {REG_HEIGHT, 2'b00};

  localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam longint unsigned RATIO_SAT = 64'hFFFF_FFFF;
  localparam longint OFFSET_HI = 64'sd2147483647;
  localparam longint OFFSET_LO = -64'sd2147483648;

  // Set collapse modes: which axes of a whole set share one coordinate.
  localparam int COLLAPSE_NONE = 0;
  localparam int COLLAPSE_X    = 1;
  localparam int COLLAPSE_Y    = 2;
  localparam int COLLAPSE_BOTH = 3;

  typedef struct {
    logic signed [CW-1:0] lo_x;
    logic signed [CW-1:0] lo_y;
    logic signed [CW-1:0] hi_x;
    logic signed [CW-1:0] hi_y;
  } shape_t;

  typedef struct {
    logic signed [CW-1:0] min_x;
    logic signed [CW-1:0] min_y;
    logic signed [CW-1:0] max_x;
    logic signed [CW-1:0] max_y;
    logic [SCALE_W-1:0]   fit;
    logic signed [SCALE_W:0] sx;
    logic signed [SCALE_W:0] sy;
    logic signed [OFF_W-1:0] off_a;
    logic signed [OFF_W-1:0] off_b;
    logic                 degen;
  } scene_fit_t;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic pready;
  logic start, busy;
  logic signed [CW-1:0] box_min_x_i, box_min_y_i, box_max_x_i, box_max_y_i;
  logic last_shape_i;
  logic result_strobe_o;
  logic signed [CW-1:0] scene_min_x_o, scene_min_y_o, scene_max_x_o, scene_max_y_o;
  logic [SCALE_W-1:0] fit_scale_o;
  logic signed [SCALE_W:0] scale_x_o, scale_y_o;
  logic signed [OFF_W-1:0] offset_a_o, offset_b_o;
  logic degenerate_o;

  // Predictor state: window registers and the running box of the open set.
  logic [WIN_W-1:0] win_w, win_h;
  logic signed [CW-1:0] acc_lo_x, acc_lo_y, acc_hi_x, acc_hi_y;
  bit set_empty;

  scene_fit_t pending_fits[$];
  int error_count;
  bit idle_on;

  viewport_fit_transform #(
    .COORD_WIDTH(CW),
    .FRAC_BITS  (FB)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .start          (start),
    .busy           (busy),
    .box_min_x_i    (box_min_x_i),
    .box_min_y_i    (box_min_y_i),
    .box_max_x_i    (box_max_x_i),
    .box_max_y_i    (box_max_y_i),
    .last_shape_i   (last_shape_i),
    .result_strobe_o(result_strobe_o),
    .scene_min_x_o  (scene_min_x_o),
    .scene_min_y_o  (scene_min_y_o),
    .scene_max_x_o  (scene_max_x_o),
    .scene_max_y_o  (scene_max_y_o),
    .fit_scale_o    (fit_scale_o),
    .scale_x_o      (scale_x_o),
    .scale_y_o      (scale_y_o),
    .offset_a_o     (offset_a_o),
    .offset_b_o     (offset_b_o),
    .degenerate_o   (degenerate_o)
  );

  // Clock: 10 ns period.
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Per-axis ratio in fixed point, saturated to 32 bits.
  function automatic longint unsigned fit_ratio(longint unsigned span, longint unsigned ext);
    longint unsigned q;
    q = (span << FB) / ext;
    return (q > RATIO_SAT) ? RATIO_SAT : q;
  endfunction

  // Offset: (span*2^FB - scale*sum) / 2^(FB+1), truncated toward zero and saturated.
  function automatic logic signed [OFF_W-1:0] fit_offset(longint unsigned span, longint scale,
                                                         longint sum);
    longint unsigned ms, mc, mag, cap;
    longint prod, num, q;
    cap = 64'd1 << 62;
    ms = (scale < 0) ? $unsigned(-scale) : $unsigned(scale);
    mc = (sum < 0) ? $unsigned(-sum) : $unsigned(sum);
    if (ms != 0 && mc > cap / ms) begin
      mag = cap;
    end else begin
      mag = ms * mc;
      if (mag > cap) mag = cap;
    end
    prod = ((scale < 0) != (sum < 0)) ? -$signed(mag) : $signed(mag);
    num = $signed(span << FB) - prod;
    q = num / (64'sd1 <<< (FB + 1));
    if (q > OFFSET_HI) q = OFFSET_HI;
    if (q < OFFSET_LO) q = OFFSET_LO;
    return q[OFF_W-1:0];
  endfunction

  // Full transform of a closed set's box under the current window.
  function automatic scene_fit_t predict_fit(logic signed [CW-1:0] lx, logic signed [CW-1:0] ly,
                                             logic signed [CW-1:0] hx, logic signed [CW-1:0] hy,
                                             logic [WIN_W-1:0] w, logic [WIN_W-1:0] h);
    longint dx, dy, sx, sy;
    longint unsigned ex, ey, lam, rx, ry;
    scene_fit_t r;
    dx = longint'(hx) - longint'(lx);
    dy = longint'(hy) - longint'(ly);
    ex = (dx < 0) ? $unsigned(-dx) : $unsigned(dx);
    ey = (dy < 0) ? $unsigned(-dy) : $unsigned(dy);
    r.degen = 1'b0;
    if (ex == 0 && ey == 0) begin
      r.degen = 1'b1;
      lam = RATIO_SAT;
    end else if (ex == 0) begin
      lam = fit_ratio(h, ey);
    end else if (ey == 0) begin
      lam = fit_ratio(w, ex);
    end else begin
      rx = fit_ratio(w, ex);
      ry = fit_ratio(h, ey);
      lam = (rx < ry) ? rx : ry;
    end
    // Screen span is +width on x and -height on y; a zero height counts as nonnegative.
    sx = (dx >= 0) ? longint'(lam) : -longint'(lam);
    sy = ((dy >= 0) == (h == 0)) ? longint'(lam) : -longint'(lam);
    r.min_x = lx;
    r.min_y = ly;
    r.max_x = hx;
    r.max_y = hy;
    r.fit = lam[SCALE_W-1:0];
    r.sx = sx[SCALE_W:0];
    r.sy = sy[SCALE_W:0];
    r.off_a = fit_offset(w, sx, longint'(lx) + longint'(hx));
    r.off_b = fit_offset(h, sy, longint'(ly) + longint'(hy));
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      error_count++;
    end
  endtask

  // Result checker: the strobe lasts one full cycle, so the falling edge sees it once.
  always @(negedge clk_i) begin
    scene_fit_t want;
    if (rst_ni && result_strobe_o) begin
      if (pending_fits.size() == 0) begin
        $error("result strobe with no scene fit expected");
        error_count++;
      end else begin
        want = pending_fits.pop_front();
        check_field("scene_min_x", 64'(want.min_x), 64'(scene_min_x_o));
        check_field("scene_min_y", 64'(want.min_y), 64'(scene_min_y_o));
        check_field("scene_max_x", 64'(want.max_x), 64'(scene_max_x_o));
        check_field("scene_max_y", 64'(want.max_y), 64'(scene_max_y_o));
        check_field("fit_scale", 64'(want.fit), 64'(fit_scale_o));
        check_field("scale_x", 64'(want.sx), 64'(scale_x_o));
        check_field("scale_y", 64'(want.sy), 64'(scale_y_o));
        check_field("offset_a", 64'(want.off_a), 64'(offset_a_o));
        check_field("offset_b", 64'(want.off_b), 64'(offset_b_o));
        check_field("degenerate", 64'(want.degen), 64'(degenerate_o));
      end
    end
  end

  // One APB transfer: setup cycle, then access cycle until pready. Reads check prdata.
  // psel drops before the task returns, so back-to-back calls never drive the bus twice in one step.
  task automatic cfg_access(bit wr, logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
    logic [WIN_W-1:0] stored;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(negedge clk_i); while (!pready);
    stored = (addr[APB_AW-1] == REG_HEIGHT) ? win_h : win_w;
    if (!wr) check_field("prdata", 64'({{(APB_DW-WIN_W){1'b0}}, stored}), 64'(prdata));
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (wr) begin
      if (addr[APB_AW-1] == REG_HEIGHT) win_h = data[WIN_W-1:0];
      else win_w = data[WIN_W-1:0];
    end
    @(posedge clk_i);
  endtask

  // Write both window registers with junk in the unused bits, then read them back.
  task automatic set_window(logic [WIN_W-1:0] w, logic [WIN_W-1:0] h);
    cfg_access(1'b1, ADDR_WIDTH, {$urandom_range(0, 1) ? 20'hFFFFF : 20'h0, w});
    cfg_access(1'b1, ADDR_HEIGHT, {20'($urandom), h});
    cfg_access(1'b0, ADDR_WIDTH, '0);
    cfg_access(1'b0, ADDR_HEIGHT, '0);
  endtask

  // Send one shape; on transfer fold it into the running box and predict the fit if last.
  task automatic send_shape(shape_t s, bit last);
    bit taken;
    if (idle_on) begin
      while ($urandom_range(99) < 13) begin
        start <= 1'b0;
        @(posedge clk_i);
      end
    end
    start        <= 1'b1;
    box_min_x_i  <= s.lo_x;
    box_min_y_i  <= s.lo_y;
    box_max_x_i  <= s.hi_x;
    box_max_y_i  <= s.hi_y;
    last_shape_i <= last;
    do begin
      @(negedge clk_i);
      taken = !busy;
      @(posedge clk_i);
    end while (!taken);
    if (set_empty) begin
      acc_lo_x = s.lo_x;
      acc_lo_y = s.lo_y;
      acc_hi_x = s.hi_x;
      acc_hi_y = s.hi_y;
    end else begin
      if (s.lo_x < acc_lo_x) acc_lo_x = s.lo_x;
      if (s.lo_y < acc_lo_y) acc_lo_y = s.lo_y;
      if (s.hi_x > acc_hi_x) acc_hi_x = s.hi_x;
      if (s.hi_y > acc_hi_y) acc_hi_y = s.hi_y;
    end
    set_empty = last;
    if (last) pending_fits.insert(pending_fits.size(),
                                  predict_fit(acc_lo_x, acc_lo_y, acc_hi_x, acc_hi_y,
                                              win_w, win_h));
  endtask

  task automatic send_box(int lx, int ly, int hx, int hy, bit last);
    shape_t s;
    s.lo_x = lx[CW-1:0];
    s.lo_y = ly[CW-1:0];
    s.hi_x = hx[CW-1:0];
    s.hi_y = hy[CW-1:0];
    send_shape(s, last);
  endtask

  // Stop sending and wait until every predicted fit has arrived and busy has settled.
  task automatic drain;
    start <= 1'b0;
    while (pending_fits.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic signed [CW-1:0] pick_edge();
    case ($urandom_range(3))
      0:       return COORD_MIN;
      1:       return COORD_MAX;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  // Random shape of a random flavor, with axes pinned when the set collapses.
  function automatic shape_t random_shape(int collapse, logic signed [CW-1:0] cx,
                                          logic signed [CW-1:0] cy);
    int kind;
    logic signed [CW-1:0] a, b, c, d;
    shape_t s;
    kind = $urandom_range(99);
    a = CW'($urandom);
    b = CW'($urandom);
    c = CW'($urandom);
    d = CW'($urandom);
    if (kind < 55) begin
      s.lo_x = (a < b) ? a : b;
      s.hi_x = (a < b) ? b : a;
      s.lo_y = (c < d) ? c : d;
      s.hi_y = (c < d) ? d : c;
    end else if (kind < 70) begin
      s.lo_x = CW'($urandom_range(0, 400) - 200);
      s.hi_x = s.lo_x + CW'($urandom_range(0, 60));
      s.lo_y = CW'($urandom_range(0, 400) - 200);
      s.hi_y = s.lo_y + CW'($urandom_range(0, 60));
    end else if (kind < 78) begin
      s.lo_x = pick_edge();
      s.hi_x = pick_edge();
      s.lo_y = pick_edge();
      s.hi_y = pick_edge();
    end else if (kind < 86) begin
      s.lo_x = a;
      s.hi_x = a;
      s.lo_y = c;
      s.hi_y = c;
    end else if (kind < 94) begin
      s.lo_x = (a < b) ? b : a;
      s.hi_x = (a < b) ? a : b;
      s.lo_y = (c < d) ? d : c;
      s.hi_y = (c < d) ? c : d;
    end else begin
      s.lo_x = a;
      s.hi_x = b;
      s.lo_y = c;
      s.hi_y = d;
    end
    if (collapse == COLLAPSE_X || collapse == COLLAPSE_BOTH) begin
      s.lo_x = cx;
      s.hi_x = cx;
    end
    if (collapse == COLLAPSE_Y || collapse == COLLAPSE_BOTH) begin
      s.lo_y = cy;
      s.hi_y = cy;
    end
    return s;
  endfunction

  // Random sets under one window setting, each closed by a last shape.
  task automatic run_random_phase(int items, logic [WIN_W-1:0] w, logic [WIN_W-1:0] h);
    int sent, len, collapse;
    logic signed [CW-1:0] cx, cy;
    set_window(w, h);
    sent = 0;
    while (sent < items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 6);
      collapse = ($urandom_range(9) < 3) ? $urandom_range(COLLAPSE_X, COLLAPSE_BOTH)
                                         : COLLAPSE_NONE;
      cx = $urandom_range(1) ? pick_edge() : CW'($urandom);
      cy = $urandom_range(1) ? pick_edge() : CW'($urandom);
      for (int k = 0; k < len; k++) begin
        send_shape(random_shape(collapse, cx, cy), k == len - 1);
      end
      sent += len;
    end
    drain();
  endtask

  // Window at its reset value, nothing written yet.
  task automatic test_reset_window;
    cfg_access(1'b0, ADDR_WIDTH, '0);
    cfg_access(1'b0, ADDR_HEIGHT, '0);
    send_box(-100, -50, 100, 50, 1'b1);
    drain();
  endtask

  // Field extremes, degenerate and single-axis boxes, inverted boxes, multi-shape sets.
  task automatic test_special_boxes;
    send_box(-32768, -32768, 0, 0, 1'b0);
    send_box(0, 0, 32767, 32767, 1'b1);
    send_box(5, 7, 5, 7, 1'b1);
    send_box(-32768, 32767, -32768, 32767, 1'b1);
    send_box(10, -200, 10, 300, 1'b1);
    send_box(-300, 40, 500, 40, 1'b1);
    send_box(100, 100, -100, -100, 1'b1);
    send_box(50, -10, -50, 10, 1'b1);
    send_box(32767, -32768, -32768, 32767, 1'b1);
    send_box(0, 0, 10, 10, 1'b0);
    send_box(-5, 3, 4, 20, 1'b0);
    send_box(2, 2, 3, 3, 1'b0);
    send_box(1, -7, 12, 8, 1'b1);
    drain();
  endtask

  // Smallest, largest and zero windows, both axes; the window changes only when idle.
  task automatic test_window_extremes;
    set_window(12'd1, 12'd1);
    send_box(-1, -1, 1, 1, 1'b1);
    drain();
    set_window(12'd4095, 12'd4095);
    send_box(-32768, -3, 32767, 3, 1'b1);
    send_box(0, 0, 0, 0, 1'b1);
    drain();
    set_window(12'd4095, 12'd1);
    send_box(-20, -9000, 20, 9000, 1'b1);
    drain();
    set_window(12'd0, 12'd0);
    send_box(-10, -10, 10, 10, 1'b1);
    send_box(3, 3, 3, 3, 1'b1);
    send_box(-8, 4, 8, 4, 1'b1);
    drain();
  endtask

  // Random sets across several window settings; one phase runs without idle cycles.
  task automatic test_random_sets;
    run_random_phase(250, 12'd640, 12'd480);
    run_random_phase(250, 12'd1, 12'd4095);
    idle_on = 1'b0;
    run_random_phase(250, 12'd4095, 12'd1);
    idle_on = 1'b1;
    run_random_phase(250, 12'd4095, 12'd4095);
    run_random_phase(250, 12'd1, 12'd1);
    run_random_phase(250, WIN_W'($urandom_range(1, 4095)), WIN_W'($urandom_range(1, 4095)));
  endtask

  initial begin
    rst_ni       <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    start        <= 1'b0;
    box_min_x_i  <= '0;
    box_min_y_i  <= '0;
    box_max_x_i  <= '0;
    box_max_y_i  <= '0;
    last_shape_i <= 1'b0;
    win_w = WIDTH_RST;
    win_h = HEIGHT_RST;
    set_empty = 1'b1;
    error_count = 0;
    idle_on = 1'b1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_window();
    test_special_boxes();
    test_window_extremes();
    test_random_sets();

    drain();
    repeat (120) @(posedge clk_i);
    if (error_count == 0 && pending_fits.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest correct run.
  initial begin
    #(10_000_000);
    $display("testbench: FAIL");
    $finish;
  end

endmodule
